/* hdl/six_bit_text_codec_assert.svh */
// Assertion macros shared by the codec modules.
`ifndef SIX_BIT_TEXT_CODEC_ASSERT_SVH
`define SIX_BIT_TEXT_CODEC_ASSERT_SVH

// Condition must never hold outside reset.
`define SCG_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SCG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/scg_pkg.sv */
package scg_pkg;

  localparam logic [7:0] CHAR_OFFSET = 8'h20;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  // One queued job: one or two result characters, last flag on the final one.
  typedef struct packed {
    logic       pair;
    logic [7:0] char0;
    logic [7:0] char1;
    logic       last;
  } entry_t;

  function automatic logic [7:0] six_to_char(input logic [5:0] v);
    return {2'b00, v} + CHAR_OFFSET;
  endfunction

endpackage

/* hdl/scg_front.sv */
module scg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output scg_pkg::entry_t   push_data_o
);

  scg_pkg::dir_e dir_q;
  logic [1:0]    pos_q, pos_d;
  logic [5:0]    held_q, held_d;
  logic          accept;
  logic          produce;
  logic [7:0]    dec_c8;
  logic [5:0]    dec_c;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign dec_c8     = in_byte_i - scg_pkg::CHAR_OFFSET;
  assign dec_c      = dec_c8[5:0];

  always_comb begin
    pos_d       = pos_q;
    held_d      = held_q;
    produce     = 1'b1;
    push_data_o = '0;
    push_data_o.last = in_last_i;
    if (dir_q == scg_pkg::DIR_ENCODE) begin
      case (pos_q)
        2'd1: begin
          push_data_o.char0 = scg_pkg::six_to_char({held_q[1:0], in_byte_i[7:4]});
          push_data_o.char1 = scg_pkg::six_to_char({in_byte_i[3:0], 2'b00});
          push_data_o.pair  = in_last_i;
          held_d = {2'b00, in_byte_i[3:0]};
          pos_d  = 2'd2;
        end
        2'd2: begin
          push_data_o.char0 = scg_pkg::six_to_char({held_q[3:0], in_byte_i[7:6]});
          push_data_o.char1 = scg_pkg::six_to_char(in_byte_i[5:0]);
          push_data_o.pair  = 1'b1;
          held_d = '0;
          pos_d  = 2'd0;
        end
        default: begin
          push_data_o.char0 = scg_pkg::six_to_char(in_byte_i[7:2]);
          push_data_o.char1 = scg_pkg::six_to_char({in_byte_i[1:0], 4'b0000});
          push_data_o.pair  = in_last_i;
          held_d = {4'b0000, in_byte_i[1:0]};
          pos_d  = 2'd1;
        end
      endcase
    end else begin
      held_d = dec_c;
      case (pos_q)
        2'd0: begin
          produce = 1'b0;
          pos_d   = 2'd1;
        end
        2'd1: begin
          push_data_o.char0 = {held_q, dec_c[5:4]};
          pos_d = 2'd2;
        end
        2'd2: begin
          push_data_o.char0 = {held_q[3:0], dec_c[5:2]};
          pos_d = 2'd3;
        end
        default: begin
          push_data_o.char0 = {held_q[1:0], dec_c};
          pos_d = 2'd0;
        end
      endcase
    end
    if (in_last_i) begin
      pos_d  = 2'd0;
      held_d = '0;
    end
  end

  assign push_o = accept && produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= scg_pkg::DIR_ENCODE;
      pos_q  <= '0;
      held_q <= '0;
    end else begin
      if (cfg_we_i) begin
        dir_q <= scg_pkg::dir_e'(cfg_wdata_i);
      end
      if (accept) begin
        pos_q  <= pos_d;
        held_q <= held_d;
      end
    end
  end

endmodule

/* hdl/scg_fifo.sv */
`include "six_bit_text_codec_assert.svh"

module scg_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  scg_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output scg_pkg::entry_t head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  scg_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `SCG_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `SCG_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `SCG_ASSERT_NEXT(a_count_track, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "count lost a push")

endmodule

/* hdl/scg_back.sv */
`include "six_bit_text_codec_assert.svh"

module scg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  scg_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       idx_q, idx_d;
  logic       load;

  assign load = !empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = idx_q ? head_i.char1 : head_i.char0;
      out_last_d  = head_i.last && (idx_q || !head_i.pair);
      pop_o       = idx_q || !head_i.pair;
      idx_d       = head_i.pair && !idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  `SCG_ASSERT_IMPL(a_second_half_held, clk_i, rst_ni, idx_q, !empty_i && head_i.pair, "second half without pair entry")
  `SCG_ASSERT_IMPL(a_pop_when_loaded, clk_i, rst_ni, pop_o, load, "pop without loading output")

endmodule

/* hdl/six_bit_text_codec.sv */
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+----------------------------
// cfg      | in        | cfg_we_i                  | cfg_wdata_i (direction)
// in       | in        | in_valid_i / in_stall_o   | in_byte_i, in_last_i
// out      | out       | out_valid_o / out_stall_i | out_byte_o, out_last_o
//
// One input transaction per cycle while the queue has room; a result passes
// through a queue entry and then the output register before it appears.
// Encoding at group position 2 or on a last byte yields two results, which the
// single output register sends one after the other; the output sets the pace.
// out_stall_i holds the output register; in_stall_o rises when the
// QUEUE_DEPTH-entry queue is full. Reset clears state, queue and direction.
module six_bit_text_codec #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic            push, full, pop, empty;
  scg_pkg::entry_t push_data, head;

  scg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .queue_full_i (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  scg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  scg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

/* verif/six_bit_text_codec_tb.sv */
module six_bit_text_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } codec_result_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  six_bit_text_codec dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  codec_result_t  expected_outputs[$];
  scg_pkg::dir_e  active_dir = scg_pkg::DIR_ENCODE;
  logic [1:0]     group_pos = 2'd0;
  logic [5:0]     carry_bits = 6'd0;

  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned encode_items = 0;
  int unsigned decode_items = 0;
  int unsigned results_checked = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned hold_off_len = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] to_printable(input logic [5:0] v);
    return {2'b00, v} + scg_pkg::CHAR_OFFSET;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    fail_count++;
    if (fail_count <= 40)
      $display("MISMATCH at %0t: %s expected %02h got %02h", $realtime, what, want, got);
  endtask

  task automatic expect_result(input logic [7:0] data, input logic last);
    expected_outputs.push_back('{data: data, last: last});
  endtask

  task automatic predict_codec_output(input logic [7:0] b, input logic last);
    logic [1:0] pos;
    logic [5:0] held;
    logic [5:0] six;
    pos  = group_pos;
    held = carry_bits;
    if (active_dir == scg_pkg::DIR_ENCODE) begin
      encode_items++;
      if (pos == 2'd3) pos = 2'd0;
      case (pos)
        2'd0: begin
          expect_result(to_printable(b[7:2]), 1'b0);
          held = {4'b0000, b[1:0]};
          if (last) expect_result(to_printable({b[1:0], 4'b0000}), 1'b1);
          pos = 2'd1;
        end
        2'd1: begin
          expect_result(to_printable({held[1:0], b[7:4]}), 1'b0);
          held = {2'b00, b[3:0]};
          if (last) expect_result(to_printable({b[3:0], 2'b00}), 1'b1);
          pos = 2'd2;
        end
        default: begin
          expect_result(to_printable({held[3:0], b[7:6]}), 1'b0);
          expect_result(to_printable(b[5:0]), last);
          held = 6'd0;
          pos  = 2'd0;
        end
      endcase
    end else begin
      decode_items++;
      six = 6'(b - scg_pkg::CHAR_OFFSET);
      case (pos)
        2'd0: pos = 2'd1;
        2'd1: begin
          expect_result({held, six[5:4]}, last);
          pos = 2'd2;
        end
        2'd2: begin
          expect_result({held[3:0], six[5:2]}, last);
          pos = 2'd3;
        end
        default: begin
          expect_result({held[1:0], six}, last);
          pos = 2'd0;
        end
      endcase
      held = six;
    end
    if (last) begin
      pos  = 2'd0;
      held = 6'd0;
    end
    group_pos  = pos;
    carry_bits = held;
  endtask

  task automatic check_result(input logic [7:0] data, input logic last);
    codec_result_t want;
    if (expected_outputs.size() == 0) begin
      report_mismatch("unexpected transaction, out_byte", 8'h00, data);
      return;
    end
    want = expected_outputs.pop_front();
    results_checked++;
    if (data !== want.data) report_mismatch("out_byte", want.data, data);
    if (last !== want.last) report_mismatch("out_last", {7'd0, want.last}, {7'd0, last});
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_byte_o, out_last_o);
    if (rst_ni && in_valid_i && in_stall_o) input_stall_cycles++;
  end

  // Receiver: random stall bursts, or one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_off_len) @(posedge clk_i);
        hold_off_len = 0;
        out_stall_i <= 1'b0;
      end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_input_byte(input logic [7:0] b, input logic last);
    in_byte_i  <= b;
    in_last_i  <= last;
    in_valid_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predict_codec_output(b, last);
    items_sent++;
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_direction(input scg_pkg::dir_e dir);
    wait_drained();
    cfg_wdata_i <= dir;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    active_dir  = dir;
  endtask

  task automatic send_random_message();
    int unsigned len;
    int unsigned shape;
    logic [7:0]  b;
    logic        last;
    len   = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    shape = $urandom_range(0, 99);
    for (int i = 0; i < len; i++) begin
      if (active_dir == scg_pkg::DIR_DECODE && $urandom_range(0, 7) != 0)
        b = 8'($urandom_range(8'h20, 8'h5F));
      else if ($urandom_range(0, 15) == 0)
        b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else
        b = 8'($urandom_range(0, 255));
      if (shape < 80) last = (i == len - 1);
      else if (shape < 92) last = ($urandom_range(0, 5) == 0);
      else last = 1'b0;
      push_input_byte(b, last);
    end
  endtask

  task automatic test_encode_extremes();
    write_direction(scg_pkg::DIR_ENCODE);
    push_input_byte(8'hFF, 1'b1);
    push_input_byte(8'hAB, 1'b0);
    push_input_byte(8'h55, 1'b1);
    push_input_byte(8'h00, 1'b0);
    push_input_byte(8'hFF, 1'b0);
    push_input_byte(8'h80, 1'b1);
    wait_drained();
  endtask

  task automatic test_decode_extremes();
    write_direction(scg_pkg::DIR_DECODE);
    push_input_byte(8'h20, 1'b0);
    push_input_byte(8'h5F, 1'b0);
    push_input_byte(8'h00, 1'b0);
    push_input_byte(8'hFF, 1'b1);
    push_input_byte(8'h41, 1'b1);
    push_input_byte(8'h7F, 1'b0);
    push_input_byte(8'h10, 1'b1);
    push_input_byte(8'h3F, 1'b0);
    push_input_byte(8'h60, 1'b0);
    push_input_byte(8'h55, 1'b1);
    wait_drained();
  endtask

  task automatic test_direction_change_mid_group();
    write_direction(scg_pkg::DIR_ENCODE);
    push_input_byte(8'hA5, 1'b0);
    write_direction(scg_pkg::DIR_DECODE);
    push_input_byte(8'h30, 1'b0);
    push_input_byte(8'h40, 1'b1);
    push_input_byte(8'h61, 1'b0);
    push_input_byte(8'h62, 1'b0);
    push_input_byte(8'h63, 1'b0);
    write_direction(scg_pkg::DIR_ENCODE);
    push_input_byte(8'h12, 1'b0);
    push_input_byte(8'h34, 1'b1);
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    write_direction(scg_pkg::DIR_ENCODE);
    tx_gaps_on   = 1'b0;
    rx_gaps_on   = 1'b0;
    hold_off_len = 150;
    for (int i = 0; i < 30; i++) push_input_byte(8'($urandom_range(0, 255)), i == 29);
    wait_drained();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_random_messages();
    int unsigned stop_at;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0) write_direction(scg_pkg::DIR_DECODE);
      else write_direction(scg_pkg::DIR_ENCODE);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      stop_at    = items_sent + 200;
      while (items_sent < stop_at) send_random_message();
    end
  endtask

  task automatic test_steady_stream();
    int unsigned stop_at;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    write_direction(scg_pkg::DIR_ENCODE);
    stop_at = items_sent + 125;
    while (items_sent < stop_at) send_random_message();
    write_direction(scg_pkg::DIR_DECODE);
    stop_at = items_sent + 125;
    while (items_sent < stop_at) send_random_message();
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_encode_extremes();
    test_decode_extremes();
    test_direction_change_mid_group();
    test_output_hold_off();
    test_random_messages();
    test_steady_stream();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d encode and %0d decode input transactions; checked %0d results.",
             encode_items, decode_items, results_checked);
    $display("Input was held back for %0d cycles, including one long output hold-off.",
             input_stall_cycles);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/scg_pkg.sv
hdl/scg_front.sv
hdl/scg_fifo.sv
hdl/scg_back.sv
hdl/six_bit_text_codec.sv
verif/six_bit_text_codec_tb.sv
